[rtl/bbps_pkg.sv]
`default_nettype none
// Shared constants, types and constant functions of the bump-mapped Blinn-Phong shader.
package bbps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int LAT    = 86;
    localparam int GX_W   = 24;
    localparam int SQ_W   = 48;
    localparam int RT_W   = 24;
    localparam int DIV_BITS = 15;
    localparam int NUM_W  = 39;
    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;

    localparam logic [15:0] GAIN_MIN = 16'd13;
    localparam logic [8:0]  Q8_ONE   = 9'd256;
    localparam logic [12:0] EXP_MIN  = 13'd256;

    localparam logic [15:0] BUMP_GAIN_RST = 16'd896;
    localparam logic [8:0]  AMBIENT_RST   = 9'd90;
    localparam logic [47:0] LIGHT_VEC_RST = 48'd49757733052416;
    localparam logic [47:0] HALF_VEC_RST  = 48'd65013210607278;
    localparam logic [23:0] LIGHT_RGB_RST = 24'hFFFFFF;
    localparam logic [24:0] FLAT_BASE_RST = 25'd13158610;
    localparam logic [8:0]  SPEC_STR_RST  = 9'd115;
    localparam logic [12:0] SPEC_EXP_RST  = 13'd1434;

    localparam logic [SQ_W-1:0]  SQ_ONE     = 48'd1;
    localparam logic [SQ_W-1:0]  SQRT_BIAS  = 48'h0001_0000_0000;
    localparam logic [RT_W-1:0]  RT_ONE     = 24'd1;
    localparam logic [NUM_W-1:0] NZ_NUM     = 39'h00_4000_0000;
    localparam logic [30:0]      ACC_ONE    = 31'h4000_0000;
    localparam logic [14:0]      Q14_ONE    = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUMP_GAIN     = 3'd0,
        CFG_AMBIENT_LEVEL = 3'd1,
        CFG_LIGHT_VECTOR  = 3'd2,
        CFG_HALF_VECTOR   = 3'd3,
        CFG_LIGHT_RGB     = 3'd4,
        CFG_FLAT_BASE     = 3'd5,
        CFG_SPEC_STRENGTH = 3'd6,
        CFG_SPEC_EXPONENT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        clear;
        logic [7:0]  alpha;
        logic [23:0] base;
    } side_t;

    function automatic logic [29:0] isqrt60(input logic [59:0] v);
        logic [29:0] res;
        logic [29:0] trial;
        logic [59:0] t60;
        res = '0;
        for (int j = 29; j >= 0; j--)
        begin
            trial = res | (30'd1 << j);
            t60 = {30'd0, trial};
            if (t60 * t60 <= v)
            begin
                res = trial;
            end
        end
        return res;
    endfunction

    // 2^(-2^-b) in Q.30 terms, built by repeated square roots
    function automatic logic [29:0] exp_root(input int b);
        logic [29:0] r;
        r = 30'h2000_0000;
        for (int i = 1; i <= b; i++)
        begin
            r = isqrt60({r, 30'd0});
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/bump_blinn_phong_pixel_shader_unit.sv]
`default_nettype none
// Throughput: one item per cycle unless the output stalls; every stage is a plain register stage.
// The pipeline halts only while the output register holds an item that is stalled.
// Depth is set by the 24-step square root, the 15-step divider and the
// 16-step log and exp chains of the specular power.
// Reset clears all valid bits and loads the configuration defaults.
module bump_blinn_phong_pixel_shader_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [bbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     height_left,
    input  logic [15:0]                     height_right,
    input  logic [15:0]                     height_up,
    input  logic [15:0]                     height_down,
    input  logic [7:0]                      src_red,
    input  logic [7:0]                      src_green,
    input  logic [7:0]                      src_blue,
    input  logic [7:0]                      src_alpha,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_alpha
);
    import bbps_pkg::*;

    localparam int VLD_SQRT_END = 28;
    localparam int VLD_DIV_END  = 44;
    localparam int VLD_POW      = 81;

    // configuration
    logic [15:0] bump_gain_reg;
    logic [8:0]  ambient_level_reg;
    logic [47:0] light_vector_reg;
    logic [47:0] half_vector_reg;
    logic [23:0] light_rgb_reg;
    logic [24:0] flat_base_reg;
    logic [8:0]  spec_strength_reg;
    logic [12:0] spec_exponent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_gain_reg     <= BUMP_GAIN_RST;
            ambient_level_reg <= AMBIENT_RST;
            light_vector_reg  <= LIGHT_VEC_RST;
            half_vector_reg   <= HALF_VEC_RST;
            light_rgb_reg     <= LIGHT_RGB_RST;
            flat_base_reg     <= FLAT_BASE_RST;
            spec_strength_reg <= SPEC_STR_RST;
            spec_exponent_reg <= SPEC_EXP_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_BUMP_GAIN:     bump_gain_reg     <= cfg_data[15:0];
                CFG_AMBIENT_LEVEL: ambient_level_reg <= cfg_data[8:0];
                CFG_LIGHT_VECTOR:  light_vector_reg  <= cfg_data[47:0];
                CFG_HALF_VECTOR:   half_vector_reg   <= cfg_data[47:0];
                CFG_LIGHT_RGB:     light_rgb_reg     <= cfg_data[23:0];
                CFG_FLAT_BASE:     flat_base_reg     <= cfg_data[24:0];
                CFG_SPEC_STRENGTH: spec_strength_reg <= cfg_data[8:0];
                CFG_SPEC_EXPONENT: spec_exponent_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [15:0] gain_eff;
    logic [8:0]  amb_eff;
    logic [8:0]  str_eff;
    logic [12:0] exp_eff;

    assign gain_eff = (bump_gain_reg < GAIN_MIN) ? GAIN_MIN : bump_gain_reg;
    assign amb_eff  = (ambient_level_reg > Q8_ONE) ? Q8_ONE : ambient_level_reg;
    assign str_eff  = (spec_strength_reg > Q8_ONE) ? Q8_ONE : spec_strength_reg;
    assign exp_eff  = (spec_exponent_reg < EXP_MIN) ? EXP_MIN : spec_exponent_reg;

    // pipeline control
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = !vld_reg[LAT-1] || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // stage 1: differences, base colour select
    logic [16:0] a_dx_reg;
    logic [16:0] a_dy_reg;
    side_t       a_side_reg;
    logic [9:0]  src_sum;
    side_t       a_side_next;

    assign src_sum = {2'b0, src_red} + {2'b0, src_green} + {2'b0, src_blue};

    always_comb
    begin
        a_side_next.clear = src_alpha < 8'd2;
        a_side_next.alpha = a_side_next.clear ? 8'd0 : src_alpha;
        if (flat_base_reg[24] || src_sum <= 10'd5)
        begin
            a_side_next.base = flat_base_reg[23:0];
        end
        else
        begin
            a_side_next.base = {src_red, src_green, src_blue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg   <= {1'b0, height_left} - {1'b0, height_right};
            a_dy_reg   <= {1'b0, height_up} - {1'b0, height_down};
            a_side_reg <= a_side_next;
        end
    end

    // stage 2: gain products
    logic [31:0] b_mx_reg;
    logic [31:0] b_my_reg;
    logic        b_sx_reg;
    logic        b_sy_reg;
    side_t       b_side_reg;
    logic [16:0] dx_abs;
    logic [16:0] dy_abs;

    assign dx_abs = a_dx_reg[16] ? (~a_dx_reg + 17'd1) : a_dx_reg;
    assign dy_abs = a_dy_reg[16] ? (~a_dy_reg + 17'd1) : a_dy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_mx_reg   <= {16'd0, dx_abs[15:0]} * {16'd0, gain_eff};
            b_my_reg   <= {16'd0, dy_abs[15:0]} * {16'd0, gain_eff};
            b_sx_reg   <= a_dx_reg[16];
            b_sy_reg   <= a_dy_reg[16];
            b_side_reg <= a_side_reg;
        end
    end

    // stage 3: round to Q.16 gradient
    logic [GX_W-1:0] c_gx_reg;
    logic [GX_W-1:0] c_gy_reg;
    logic            c_sx_reg;
    logic            c_sy_reg;
    side_t           c_side_reg;
    logic [32:0]     gx_rnd;
    logic [32:0]     gy_rnd;

    assign gx_rnd = {1'b0, b_mx_reg} + 33'd256;
    assign gy_rnd = {1'b0, b_my_reg} + 33'd256;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_gx_reg   <= gx_rnd[32:9];
            c_gy_reg   <= gy_rnd[32:9];
            c_sx_reg   <= b_sx_reg;
            c_sy_reg   <= b_sy_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // stage 4: squares
    logic [SQ_W-1:0] d_sqx_reg;
    logic [SQ_W-1:0] d_sqy_reg;
    logic [GX_W-1:0] d_gx_reg;
    logic [GX_W-1:0] d_gy_reg;
    logic            d_sx_reg;
    logic            d_sy_reg;
    side_t           d_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_sqx_reg  <= {24'd0, c_gx_reg} * {24'd0, c_gx_reg};
            d_sqy_reg  <= {24'd0, c_gy_reg} * {24'd0, c_gy_reg};
            d_gx_reg   <= c_gx_reg;
            d_gy_reg   <= c_gy_reg;
            d_sx_reg   <= c_sx_reg;
            d_sy_reg   <= c_sy_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // stages 5..29: length, one root bit per stage
    logic [SQ_W-1:0] sq_rem_reg  [RT_W+1];
    logic [RT_W-1:0] sq_root_reg [RT_W+1];
    logic [GX_W-1:0] sq_gx_reg   [RT_W+1];
    logic [GX_W-1:0] sq_gy_reg   [RT_W+1];
    logic            sq_sx_reg   [RT_W+1];
    logic            sq_sy_reg   [RT_W+1];
    side_t           sq_side_reg [RT_W+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= d_sqx_reg + d_sqy_reg + SQRT_BIAS;
            sq_root_reg[0] <= '0;
            sq_gx_reg[0]   <= d_gx_reg;
            sq_gy_reg[0]   <= d_gy_reg;
            sq_sx_reg[0]   <= d_sx_reg;
            sq_sy_reg[0]   <= d_sy_reg;
            sq_side_reg[0] <= d_side_reg;
        end
    end

    for (genvar k = 0; k < RT_W; k++)
    begin : g_sqrt
        localparam int J = RT_W - 1 - k;
        logic [SQ_W-1:0] inc;
        logic            take;

        assign inc  = ({{(SQ_W-RT_W){1'b0}}, sq_root_reg[k]} << (J + 1)) + (SQ_ONE << (2 * J));
        assign take = sq_rem_reg[k] >= inc;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1]  <= take ? (sq_rem_reg[k] - inc) : sq_rem_reg[k];
                sq_root_reg[k+1] <= take ? (sq_root_reg[k] | (RT_ONE << J)) : sq_root_reg[k];
                sq_gx_reg[k+1]   <= sq_gx_reg[k];
                sq_gy_reg[k+1]   <= sq_gy_reg[k];
                sq_sx_reg[k+1]   <= sq_sx_reg[k];
                sq_sy_reg[k+1]   <= sq_sy_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // stages 30..45: normal = g / r, rounded, three lanes
    logic [NUM_W-1:0]    dv_rem_reg  [DIV_BITS+1][3];
    logic [DIV_BITS-1:0] dv_q_reg    [DIV_BITS+1][3];
    logic [RT_W-1:0]     dv_d_reg    [DIV_BITS+1];
    logic                dv_sx_reg   [DIV_BITS+1];
    logic                dv_sy_reg   [DIV_BITS+1];
    side_t               dv_side_reg [DIV_BITS+1];
    logic [NUM_W-1:0]    half_r;

    assign half_r = {{(NUM_W-RT_W){1'b0}}, sq_root_reg[RT_W] >> 1};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0][0] <= {1'b0, sq_gx_reg[RT_W], 14'd0} + half_r;
            dv_rem_reg[0][1] <= {1'b0, sq_gy_reg[RT_W], 14'd0} + half_r;
            dv_rem_reg[0][2] <= NZ_NUM + half_r;
            dv_q_reg[0][0]   <= '0;
            dv_q_reg[0][1]   <= '0;
            dv_q_reg[0][2]   <= '0;
            dv_d_reg[0]      <= sq_root_reg[RT_W];
            dv_sx_reg[0]     <= sq_sx_reg[RT_W];
            dv_sy_reg[0]     <= sq_sy_reg[RT_W];
            dv_side_reg[0]   <= sq_side_reg[RT_W];
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        localparam int I = DIV_BITS - 1 - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = {{(NUM_W-RT_W){1'b0}}, dv_d_reg[k]} << I;

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic take;
            assign take = dv_rem_reg[k][c] >= dsh;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[k+1][c] <= take ? (dv_rem_reg[k][c] - dsh) : dv_rem_reg[k][c];
                    dv_q_reg[k+1][c]   <= {dv_q_reg[k][c][DIV_BITS-1:1], 1'b0}
                                          | dv_q_reg[k][c] | (DIV_BITS'(take) << I);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_sx_reg[k+1]   <= dv_sx_reg[k];
                dv_sy_reg[k+1]   <= dv_sy_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // stage 46: dot product terms
    logic signed [15:0] nvec [3];
    logic signed [31:0] g_pl_reg [3];
    logic signed [31:0] g_ph_reg [3];
    side_t              g_side_reg;

    always_comb
    begin
        nvec[0] = dv_sx_reg[DIV_BITS] ? -$signed({1'b0, dv_q_reg[DIV_BITS][0]})
                                      : $signed({1'b0, dv_q_reg[DIV_BITS][0]});
        nvec[1] = dv_sy_reg[DIV_BITS] ? -$signed({1'b0, dv_q_reg[DIV_BITS][1]})
                                      : $signed({1'b0, dv_q_reg[DIV_BITS][1]});
        nvec[2] = $signed({1'b0, dv_q_reg[DIV_BITS][2]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                g_pl_reg[c] <= nvec[c] * $signed(light_vector_reg[16*c +: 16]);
                g_ph_reg[c] <= nvec[c] * $signed(half_vector_reg[16*c +: 16]);
            end
            g_side_reg <= dv_side_reg[DIV_BITS];
        end
    end

    // stage 47: N.L and N.H
    function automatic logic [14:0] dot_sat(input logic signed [31:0] p0,
                                            input logic signed [31:0] p1,
                                            input logic signed [31:0] p2);
        logic signed [33:0] s;
        logic [34:0]        t;
        s = 34'(p0) + 34'(p1) + 34'(p2);
        t = {1'b0, s} + 35'd8192;
        t = t >> 14;
        if (s <= 34'sd0)
        begin
            return '0;
        end
        else if (t > 35'd16384)
        begin
            return Q14_ONE;
        end
        return t[14:0];
    endfunction

    logic [14:0] h_diff_reg;
    logic [14:0] h_nh_reg;
    side_t       h_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_diff_reg <= dot_sat(g_pl_reg[0], g_pl_reg[1], g_pl_reg[2]);
            h_nh_reg   <= dot_sat(g_ph_reg[0], g_ph_reg[1], g_ph_reg[2]);
            h_side_reg <= g_side_reg;
        end
    end

    // stage 48: shade, pow input normalization
    // stages 49..64: log2 fraction, one squaring per stage
    logic [30:0] lg_m_reg     [LOG_STEPS+1];
    logic [15:0] lg_f_reg     [LOG_STEPS+1];
    logic [3:0]  lg_k_reg     [LOG_STEPS+1];
    logic        lg_zero_reg  [LOG_STEPS+1];
    logic        lg_one_reg   [LOG_STEPS+1];
    logic [14:0] lg_shade_reg [LOG_STEPS+1];
    side_t       lg_side_reg  [LOG_STEPS+1];

    logic [23:0] dif_term;
    logic [14:0] shade_next;
    logic [3:0]  msb;
    logic [3:0]  norm_k;
    logic [14:0] norm_m;

    assign dif_term   = {15'd0, Q8_ONE - amb_eff} * {9'd0, h_diff_reg} + 24'd128;
    assign shade_next = {amb_eff, 6'd0} + dif_term[22:8];

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 14; i++)
        begin
            if (h_nh_reg[i])
            begin
                msb = 4'(i);
            end
        end
        norm_k = 4'd14 - msb;
        norm_m = h_nh_reg << norm_k;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_m_reg[0]     <= {norm_m, 16'd0};
            lg_f_reg[0]     <= '0;
            lg_k_reg[0]     <= norm_k;
            lg_zero_reg[0]  <= h_nh_reg == 15'd0;
            lg_one_reg[0]   <= h_nh_reg[14];
            lg_shade_reg[0] <= shade_next;
            lg_side_reg[0]  <= h_side_reg;
        end
    end

    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_log
        logic [61:0] sq;
        logic [31:0] sqv;

        assign sq  = {31'd0, lg_m_reg[k]} * {31'd0, lg_m_reg[k]};
        assign sqv = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lg_m_reg[k+1]     <= sqv[31] ? sqv[31:1] : sqv[30:0];
                lg_f_reg[k+1]     <= {lg_f_reg[k][14:0], sqv[31]};
                lg_k_reg[k+1]     <= lg_k_reg[k];
                lg_zero_reg[k+1]  <= lg_zero_reg[k];
                lg_one_reg[k+1]   <= lg_one_reg[k];
                lg_shade_reg[k+1] <= lg_shade_reg[k];
                lg_side_reg[k+1]  <= lg_side_reg[k];
            end
        end
    end

    // stage 65: scale log by exponent
    // stages 66..81: exp2 of the fraction, one root per stage
    logic [30:0] ex_acc_reg   [EXP_STEPS+1];
    logic [15:0] ex_fr_reg    [EXP_STEPS+1];
    logic [3:0]  ex_ip_reg    [EXP_STEPS+1];
    logic        ex_zero_reg  [EXP_STEPS+1];
    logic        ex_one_reg   [EXP_STEPS+1];
    logic [14:0] ex_shade_reg [EXP_STEPS+1];
    side_t       ex_side_reg  [EXP_STEPS+1];

    logic [19:0] log_l;
    logic [32:0] log_q;

    assign log_l = {lg_k_reg[LOG_STEPS], 16'd0} - {4'd0, lg_f_reg[LOG_STEPS]};
    assign log_q = {13'd0, log_l} * {20'd0, exp_eff} + 33'd128;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_acc_reg[0]   <= ACC_ONE;
            ex_fr_reg[0]    <= log_q[23:8];
            ex_ip_reg[0]    <= log_q[27:24];
            ex_zero_reg[0]  <= lg_zero_reg[LOG_STEPS] || (log_q[32:24] >= 9'd15);
            ex_one_reg[0]   <= lg_one_reg[LOG_STEPS];
            ex_shade_reg[0] <= lg_shade_reg[LOG_STEPS];
            ex_side_reg[0]  <= lg_side_reg[LOG_STEPS];
        end
    end

    for (genvar k = 0; k < EXP_STEPS; k++)
    begin : g_exp
        localparam logic [29:0] ROOT = exp_root(k + 1);
        logic [60:0] prod;

        assign prod = {30'd0, ex_acc_reg[k]} * {31'd0, ROOT};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_acc_reg[k+1]   <= ex_fr_reg[k][EXP_STEPS-1-k] ? prod[60:30] : ex_acc_reg[k];
                ex_fr_reg[k+1]    <= ex_fr_reg[k];
                ex_ip_reg[k+1]    <= ex_ip_reg[k];
                ex_zero_reg[k+1]  <= ex_zero_reg[k];
                ex_one_reg[k+1]   <= ex_one_reg[k];
                ex_shade_reg[k+1] <= ex_shade_reg[k];
                ex_side_reg[k+1]  <= ex_side_reg[k];
            end
        end
    end

    // stage 82: final shift of pow
    logic [14:0] pw_reg;
    logic [14:0] pw_shade_reg;
    side_t       pw_side_reg;
    logic [31:0] pw_sum;
    logic [31:0] pw_shr;
    logic [14:0] pw_next;

    always_comb
    begin
        pw_sum = {1'b0, ex_acc_reg[EXP_STEPS]}
                 + (32'd1 << (5'(ex_ip_reg[EXP_STEPS]) + 5'd15));
        pw_shr = pw_sum >> (5'(ex_ip_reg[EXP_STEPS]) + 5'd16);
        if (ex_one_reg[EXP_STEPS])
        begin
            pw_next = Q14_ONE;
        end
        else if (ex_zero_reg[EXP_STEPS])
        begin
            pw_next = '0;
        end
        else
        begin
            pw_next = pw_shr[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_reg       <= pw_next;
            pw_shade_reg <= ex_shade_reg[EXP_STEPS];
            pw_side_reg  <= ex_side_reg[EXP_STEPS];
        end
    end

    // stage 83: specular
    logic [14:0] sp_spec_reg;
    logic [14:0] sp_shade_reg;
    side_t       sp_side_reg;
    logic [23:0] spec_full;

    assign spec_full = {9'd0, pw_reg} * {15'd0, str_eff} + 24'd128;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_spec_reg  <= spec_full[22:8];
            sp_shade_reg <= pw_shade_reg;
            sp_side_reg  <= pw_side_reg;
        end
    end

    // stages 84..86: colour
    logic [23:0] c1_sum_reg [3];
    side_t       c1_side_reg;
    logic [31:0] c2_num_reg [3];
    side_t       c2_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                c1_sum_reg[c] <= {16'd0, sp_side_reg.base[16-8*c +: 8]} * {9'd0, sp_shade_reg}
                                 + {9'd0, sp_spec_reg} * 24'd255;
                c2_num_reg[c] <= {24'd0, light_rgb_reg[16-8*c +: 8]} * {8'd0, c1_sum_reg[c]};
            end
            c1_side_reg <= sp_side_reg;
            c2_side_reg <= c1_side_reg;
        end
    end

    logic [7:0] out_rgb_reg [3];
    logic [7:0] out_alpha_reg;
    logic [7:0] chan_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [32:0] t;
            logic [18:0] u;
            logic [16:0] d;
            t = {1'b0, c2_num_reg[c]} + 33'd2088960;
            u = t[32:14];
            d = {1'b0, u[15:0]} + {9'd0, u[15:8]} + 17'd1;
            if (c2_side_reg.clear)
            begin
                chan_next[c] = '0;
            end
            else if (u >= 19'd65280)
            begin
                chan_next[c] = 8'd255;
            end
            else
            begin
                chan_next[c] = d[15:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_rgb_reg[c] <= chan_next[c];
            end
            out_alpha_reg <= c2_side_reg.alpha;
        end
    end

    assign out_red   = out_rgb_reg[0];
    assign out_green = out_rgb_reg[1];
    assign out_blue  = out_rgb_reg[2];
    assign out_alpha = out_alpha_reg;

`ifndef ASSERT_OFF
    a_transparent_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_alpha < 8'd2 |-> out_red == 8'd0 && out_green == 8'd0
                                          && out_blue == 8'd0)
        else $error("transparent item with nonzero colour");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VLD_SQRT_END] |-> sq_root_reg[RT_W] >= 24'd65536)
        else $error("vector length below one");

    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VLD_DIV_END] |=> dv_q_reg[DIV_BITS][2] <= Q14_ONE
                                 || !vld_reg[VLD_DIV_END+1])
        else $error("normal z out of range");

    a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[VLD_POW] |-> pw_reg <= Q14_ONE)
        else $error("specular power above one");
`endif

endmodule
`default_nettype wire

[bench/tb_bump_blinn_phong_pixel_shader_unit.sv]
// Testbench of the bump-mapped Blinn-Phong shader: directed and random pixels checked against a predictor.
module tb_bump_blinn_phong_pixel_shader_unit;
    import bbps_pkg::*;

    typedef struct packed {
        logic [15:0] hl;
        logic [15:0] hr;
        logic [15:0] hu;
        logic [15:0] hd;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } pixel_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } shaded_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write_en = 0;
    cfg_reg_t    cfg_index = CFG_BUMP_GAIN;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    pixel_t      px = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [7:0]  out_red, out_green, out_blue, out_alpha;

    logic [15:0] gain_q;
    logic [8:0]  amb_q;
    logic [47:0] light_q;
    logic [47:0] half_q;
    logic [23:0] lrgb_q;
    logic [24:0] flat_q;
    logic [8:0]  str_q;
    logic [12:0] exp_q;

    shaded_t     shaded_q[$];
    int          errors = 0;
    int          idle_pct = 20;
    int          quiet = 0;

    bump_blinn_phong_pixel_shader_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .height_left(px.hl), .height_right(px.hr), .height_up(px.hu), .height_down(px.hd),
        .src_red(px.r), .src_green(px.g), .src_blue(px.b), .src_alpha(px.a),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint div_round(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint unsigned dot_clamped(input longint nx, input longint ny,
                                                    input longint nz, input logic [47:0] v);
        longint s;
        longint unsigned d;
        s = nx * longint'($signed(v[15:0])) + ny * longint'($signed(v[31:16]))
            + nz * longint'($signed(v[47:32]));
        if (s <= 0)
            return 0;
        d = (s + 8192) >> 14;
        return d > 16384 ? 16384 : d;
    endfunction

    function automatic longint unsigned spec_power(input longint unsigned x,
                                                   input longint unsigned e);
        longint unsigned m, f, lg, q, ip, fr, acc, root;
        int k;
        f = 0;
        k = 0;
        if (x == 0)
            return 0;
        if (x >= 16384)
            return 16384;
        m = x;
        while (m < 16384)
        begin
            m <<= 1;
            k++;
        end
        m <<= 16;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            f <<= 1;
            if (m >= (64'd1 << 31))
            begin
                f |= 1;
                m >>= 1;
            end
        end
        lg = (longint'(k) << 16) - f;
        q = (lg * e + 128) >> 8;
        ip = q >> 16;
        fr = q & 16'hFFFF;
        if (ip >= 15)
            return 0;
        acc = 64'd1 << 30;
        root = 64'd1 << 29;
        for (int i = 1; i <= 16; i++)
        begin
            root = sqrt_floor(root << 30);
            if (fr & (64'd1 << (16 - i)))
                acc = (acc * root) >> 30;
        end
        return (acc + (64'd1 << (15 + ip))) >> (16 + ip);
    endfunction

    function automatic shaded_t shade_pixel(input pixel_t p);
        shaded_t o;
        longint unsigned gain, amb, str, ex, diff, shade, spec, rr, l, num, v;
        longint dx, dy, gx, gy, nx, ny, nz;
        logic [7:0] base[3];
        if (p.a < 2)
            return '0;
        gain = gain_q < 13 ? 13 : gain_q;
        amb = amb_q > 256 ? 256 : amb_q;
        str = str_q > 256 ? 256 : str_q;
        ex = exp_q < 256 ? 256 : exp_q;
        dx = longint'(p.hl) - longint'(p.hr);
        dy = longint'(p.hu) - longint'(p.hd);
        gx = div_round(dx * longint'(gain), 512);
        gy = div_round(dy * longint'(gain), 512);
        rr = sqrt_floor(gx * gx + gy * gy + (64'd1 << 32));
        nx = div_round(gx * 16384, rr);
        ny = div_round(gy * 16384, rr);
        nz = div_round(64'd1 << 30, rr);
        diff = dot_clamped(nx, ny, nz, light_q);
        shade = amb * 64 + (((256 - amb) * diff + 128) >> 8);
        spec = str == 0 ? 0 : (spec_power(dot_clamped(nx, ny, nz, half_q), ex) * str + 128) >> 8;
        if (flat_q[24] || (int'(p.r) + int'(p.g) + int'(p.b)) <= 5)
        begin
            base[0] = flat_q[23:16];
            base[1] = flat_q[15:8];
            base[2] = flat_q[7:0];
        end
        else
        begin
            base[0] = p.r;
            base[1] = p.g;
            base[2] = p.b;
        end
        for (int c = 0; c < 3; c++)
        begin
            l = (lrgb_q >> (16 - 8 * c)) & 8'hFF;
            num = l * (base[c] * shade + 255 * spec);
            v = (num + 255 * 8192) / (255 * 16384);
            if (c == 0) o.r = 8'(v > 255 ? 255 : v);
            if (c == 1) o.g = 8'(v > 255 ? 255 : v);
            if (c == 2) o.b = 8'(v > 255 ? 255 : v);
        end
        o.a = p.a;
        return o;
    endfunction

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        px <= p;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shaded_q.push_back(shade_pixel(p));
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        in_valid <= 0;
        while (shaded_q.size() != 0)
            @(negedge clk);
        repeat (LAT + 10) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 0;
        @(negedge clk);
        case (idx)
            CFG_BUMP_GAIN:     gain_q = val[15:0];
            CFG_AMBIENT_LEVEL: amb_q = val[8:0];
            CFG_LIGHT_VECTOR:  light_q = val;
            CFG_HALF_VECTOR:   half_q = val;
            CFG_LIGHT_RGB:     lrgb_q = val[23:0];
            CFG_FLAT_BASE:     flat_q = val[24:0];
            CFG_SPEC_STRENGTH: str_q = val[8:0];
            default:           exp_q = val[12:0];
        endcase
    endtask

    function automatic logic [47:0] unit_vec(input int x, input int y, input int z);
        logic [15:0] a, b, c;
        a = 16'(x);
        b = 16'(y);
        c = 16'(z);
        return {c, b, a};
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = {$urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0: p.a = 8'($urandom_range(1));
            1: {p.r, p.g, p.b} = {8'($urandom_range(2)), 8'($urandom_range(2)), 8'($urandom_range(1))};
            2, 3, 4:
            begin
                p.hr = p.hl + 16'($urandom_range(600)) - 16'd300;
                p.hd = p.hu + 16'($urandom_range(600)) - 16'd300;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        pixel_t p;
        p = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'd200, 8'd100, 8'd50, 8'd255};
        send_pixel(p);
        p.hl = 16'hFFFF; p.hr = 16'h0000;
        send_pixel(p);
        p.hl = 16'h0000; p.hr = 16'hFFFF; p.hu = 16'hFFFF; p.hd = 16'h0000;
        send_pixel(p);
        p.hu = 16'h0000; p.hd = 16'hFFFF;
        send_pixel(p);
        p = '{16'h1234, 16'h1200, 16'h5678, 16'h5690, 8'd255, 8'd255, 8'd255, 8'd1};
        send_pixel(p);
        p.a = 0;
        send_pixel(p);
        p.a = 2;
        send_pixel(p);
        p.r = 0; p.g = 0; p.b = 5;
        send_pixel(p);
        p.b = 6;
        send_pixel(p);
        p.r = 0; p.g = 0; p.b = 0; p.a = 8'hFF;
        send_pixel(p);
        p = '{16'h4000, 16'h4001, 16'h4000, 16'h3FFF, 8'd255, 8'd255, 8'd255, 8'd128};
        send_pixel(p);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel());
    endtask

    task automatic test_config_extremes();
        drain_and_settle();
        write_reg(CFG_BUMP_GAIN, 48'd0);
        write_reg(CFG_AMBIENT_LEVEL, 48'd511);
        write_reg(CFG_SPEC_STRENGTH, 48'd511);
        write_reg(CFG_SPEC_EXPONENT, 48'd0);
        write_reg(CFG_FLAT_BASE, 48'h1FFFFFF);
        write_reg(CFG_LIGHT_RGB, 48'h000000);
        test_directed();
        drain_and_settle();
        write_reg(CFG_LIGHT_RGB, 48'hFF7F01);
        test_random(60);
        drain_and_settle();
        write_reg(CFG_BUMP_GAIN, 48'hFFFF);
        write_reg(CFG_AMBIENT_LEVEL, 48'd0);
        write_reg(CFG_SPEC_STRENGTH, 48'd0);
        write_reg(CFG_SPEC_EXPONENT, 48'h1FFF);
        write_reg(CFG_FLAT_BASE, 48'h0FFFFFF);
        write_reg(CFG_LIGHT_VECTOR, unit_vec(-16384, 0, 0));
        write_reg(CFG_HALF_VECTOR, unit_vec(0, 16384, 0));
        test_directed();
        test_random(60);
        drain_and_settle();
        write_reg(CFG_BUMP_GAIN, 48'd13);
        write_reg(CFG_AMBIENT_LEVEL, 48'd256);
        write_reg(CFG_SPEC_STRENGTH, 48'd1);
        write_reg(CFG_SPEC_EXPONENT, 48'd256);
        write_reg(CFG_LIGHT_VECTOR, unit_vec(0, 0, 16384));
        write_reg(CFG_HALF_VECTOR, unit_vec(0, 0, 16384));
        test_random(60);
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_settle();
            write_reg(CFG_BUMP_GAIN, 48'($urandom_range(4000, 13)));
            write_reg(CFG_AMBIENT_LEVEL, 48'($urandom_range(256)));
            write_reg(CFG_LIGHT_VECTOR, 48'({$urandom, $urandom}));
            write_reg(CFG_HALF_VECTOR, (ph % 2) ? 48'({$urandom, $urandom})
                : unit_vec($urandom_range(8000) - 4000, $urandom_range(8000) - 4000, 15000));
            write_reg(CFG_LIGHT_RGB, 48'($urandom));
            write_reg(CFG_FLAT_BASE, 48'($urandom));
            write_reg(CFG_SPEC_STRENGTH, 48'($urandom_range(256)));
            write_reg(CFG_SPEC_EXPONENT, 48'($urandom_range(6554, 256)));
            idle_pct = (ph == 3) ? 0 : 20;
            test_random(110);
        end
        idle_pct = 20;
    endtask

    always @(negedge clk)
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < 20);

    always @(posedge clk)
    begin
        shaded_t want, got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_red, out_green, out_blue, out_alpha};
            if (shaded_q.size() == 0)
            begin
                $display("%0t unexpected item: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = shaded_q.pop_front();
                if (want.r !== got.r)
                    $display("%0t red: expected %0d actual %0d", $time, want.r, got.r);
                if (want.g !== got.g)
                    $display("%0t green: expected %0d actual %0d", $time, want.g, got.g);
                if (want.b !== got.b)
                    $display("%0t blue: expected %0d actual %0d", $time, want.b, got.b);
                if (want.a !== got.a)
                    $display("%0t alpha: expected %0d actual %0d", $time, want.a, got.a);
                if (want !== got)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("tb_bump_blinn_phong_pixel_shader_unit failed");
            $finish;
        end
    end

    initial
    begin
        gain_q = BUMP_GAIN_RST;
        amb_q = AMBIENT_RST;
        light_q = LIGHT_VEC_RST;
        half_q = HALF_VEC_RST;
        lrgb_q = LIGHT_RGB_RST;
        flat_q = FLAT_BASE_RST;
        str_q = SPEC_STR_RST;
        exp_q = SPEC_EXP_RST;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_random(100);
        test_config_extremes();
        test_random_configs();
        drain_and_settle();
        if (errors == 0 && shaded_q.size() == 0)
            $display("tb_bump_blinn_phong_pixel_shader_unit passed");
        else
            $display("tb_bump_blinn_phong_pixel_shader_unit failed");
        $finish;
    end
endmodule
